// ===== rtl/core/disjoint_set_union_find_macros.svh =====
// Assertion macros used by the union-find RTL.
`ifndef DISJOINT_SET_UNION_FIND_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_MACROS_SVH

`ifndef SYNTHESIS

// Check that is switched off while the active-low reset is asserted.
`define DSU_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define DSU_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DSU_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DSU_ASSERT_ANY(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/dsu_pkg.sv =====
// Types and constants of the union-find block.
`timescale 1ns / 1ps

package dsu_pkg;

    localparam int IDX_W   = 12;
    localparam int ENTRY_W = IDX_W + 1;
    // Compare width that holds the largest supported element count.
    localparam int CMP_W   = 17;
    // Index range that the 12-bit fields can reach.
    localparam int IDX_SPAN = 4096;

    localparam logic CMD_FIND  = 1'b0;
    localparam logic CMD_UNION = 1'b1;

    typedef struct packed {
        logic             root;
        logic [IDX_W-1:0] link;
    } t_entry;

    localparam t_entry ROOT_ENTRY = '{root: 1'b1, link: '0};

endpackage

// ===== rtl/core/dsu_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dsu_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/disjoint_set_union_find.sv =====
// Top level of the union-find block: request sequencer around the parent table RAM.
`timescale 1ns / 1ps
`include "disjoint_set_union_find_macros.svh"

// Usage: a request word (command, first_index, second_index) is taken at a rising
// edge with start high and busy low. busy then stays high until the result word
// is shown; exactly one result word follows each request, held on the o_ ports
// for one cycle and marked by o_valid. The receiver cannot stall, so it must take
// the word in that cycle.
// Sequence: a find walks the chain from its first index up to its root in S_REQ_A,
// S_WALK_A and S_GOT_A. A union also walks the second chain in S_REQ_B, S_WALK_B and
// S_GOT_B, then links the roots in S_LINK. One table read per cycle along a chain
// is the limit: each link read from the parent RAM gives the address of the next read.
// A new request can be accepted in the cycle the result is strobed.
// Reset: after i_rst_n is released the table is swept, one entry per cycle, to
// mark every element as a root; the sweep covers min(NUM_ELEMENTS, 4096) entries,
// with busy held high throughout.
// Indices at or above NUM_ELEMENTS act as roots of themselves and are never written.
module disjoint_set_union_find #(
    parameter int NUM_ELEMENTS = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_command,
    input  logic [dsu_pkg::IDX_W-1:0] i_first_index,
    input  logic [dsu_pkg::IDX_W-1:0] i_second_index,
    output logic                    o_valid,
    output logic [dsu_pkg::IDX_W-1:0] o_first_root,
    output logic [dsu_pkg::IDX_W-1:0] o_second_root,
    output logic                    o_merged
);

    localparam int DEPTH  = (NUM_ELEMENTS < dsu_pkg::IDX_SPAN) ? NUM_ELEMENTS
                                                              : dsu_pkg::IDX_SPAN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [dsu_pkg::CMP_W-1:0] N_LIM = dsu_pkg::CMP_W'(NUM_ELEMENTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REQ_A,
        S_WALK_A,
        S_GOT_A,
        S_REQ_B,
        S_WALK_B,
        S_GOT_B,
        S_LINK
    } t_state;

    t_state                   r_state;
    logic [ADDR_W-1:0]        r_clr;
    logic                     r_cmd;
    logic [dsu_pkg::IDX_W-1:0] r_a;
    logic [dsu_pkg::IDX_W-1:0] r_b;
    logic [dsu_pkg::IDX_W-1:0] r_cur;
    logic [dsu_pkg::IDX_W-1:0] r_ra;
    logic [dsu_pkg::IDX_W-1:0] r_rb;
    logic                     r_valid;
    logic [dsu_pkg::IDX_W-1:0] r_out_first;
    logic [dsu_pkg::IDX_W-1:0] r_out_second;
    logic                     r_out_merged;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    dsu_pkg::t_entry          wdata;
    logic [ADDR_W-1:0]        raddr;
    logic [dsu_pkg::ENTRY_W-1:0] rdata_raw;
    dsu_pkg::t_entry          rdata;

    function automatic logic in_table(input logic [dsu_pkg::IDX_W-1:0] x);
        return {{(dsu_pkg::CMP_W - dsu_pkg::IDX_W){1'b0}}, x} < N_LIM;
    endfunction

    assign rdata = dsu_pkg::t_entry'(rdata_raw);

    dsu_ram #(
        .WIDTH (dsu_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    // Table write port: clearing sweep, the two compressions and the root link.
    always_comb begin
        we    = 1'b0;
        waddr = r_clr;
        wdata = dsu_pkg::ROOT_ENTRY;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
            end
            S_GOT_A: begin
                we    = (r_cmd == dsu_pkg::CMD_UNION) && (r_ra != r_a);
                waddr = r_a[ADDR_W-1:0];
                wdata = '{root: 1'b0, link: r_ra};
            end
            S_GOT_B: begin
                we    = (r_rb != r_b);
                waddr = r_b[ADDR_W-1:0];
                wdata = '{root: 1'b0, link: r_rb};
            end
            S_LINK: begin
                we    = (r_ra != r_rb) && in_table(r_ra);
                waddr = r_ra[ADDR_W-1:0];
                wdata = '{root: 1'b0, link: r_rb};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // While walking, the link just read is the next address to fetch.
    always_comb begin
        if (r_state == S_WALK_A || r_state == S_WALK_B) begin
            raddr = rdata.link[ADDR_W-1:0];
        end else begin
            raddr = r_cur[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_command;
                        r_a     <= i_first_index;
                        r_b     <= i_second_index;
                        r_cur   <= i_first_index;
                        r_state <= S_REQ_A;
                    end
                end
                S_REQ_A: begin
                    if (in_table(r_cur)) begin
                        r_state <= S_WALK_A;
                    end else begin
                        r_ra    <= r_cur;
                        r_state <= S_GOT_A;
                    end
                end
                S_WALK_A: begin
                    if (rdata.root) begin
                        r_ra    <= r_cur;
                        r_state <= S_GOT_A;
                    end else if (!in_table(rdata.link)) begin
                        r_ra    <= rdata.link;
                        r_state <= S_GOT_A;
                    end else begin
                        r_cur <= rdata.link;
                    end
                end
                S_GOT_A: begin
                    if (r_cmd == dsu_pkg::CMD_FIND) begin
                        r_valid      <= 1'b1;
                        r_out_first  <= r_ra;
                        r_out_second <= '0;
                        r_out_merged <= 1'b0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cur   <= r_b;
                        r_state <= S_REQ_B;
                    end
                end
                S_REQ_B: begin
                    if (in_table(r_cur)) begin
                        r_state <= S_WALK_B;
                    end else begin
                        r_rb    <= r_cur;
                        r_state <= S_GOT_B;
                    end
                end
                S_WALK_B: begin
                    if (rdata.root) begin
                        r_rb    <= r_cur;
                        r_state <= S_GOT_B;
                    end else if (!in_table(rdata.link)) begin
                        r_rb    <= rdata.link;
                        r_state <= S_GOT_B;
                    end else begin
                        r_cur <= rdata.link;
                    end
                end
                S_GOT_B: begin
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_valid      <= 1'b1;
                    r_out_first  <= r_ra;
                    r_out_second <= r_rb;
                    r_out_merged <= (r_ra != r_rb) && in_table(r_ra);
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_first_root  = r_out_first;
    assign o_second_root = r_out_second;
    assign o_merged      = r_out_merged;

    `DSU_ASSERT_ANY(a_clear_after_reset, i_clk, !i_rst_n |=> busy, "table sweep not started")
    `DSU_ASSERT_RST(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy, "request not taken")
    `DSU_ASSERT_RST(a_single_strobe, i_clk, i_rst_n, o_valid |=> !o_valid, "result word repeated")
    `DSU_ASSERT_RST(a_strobe_idle, i_clk, i_rst_n, o_valid |-> !busy, "result shown while busy")
    `DSU_ASSERT_RST(a_merge_roots, i_clk, i_rst_n, o_valid && o_merged |-> o_first_root != o_second_root, "merge of equal roots")

endmodule
